// ===== hdl/tsi_pkg.sv =====
package tsi_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_US  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 3'd4;

  localparam logic [31:0] RST_CRUISE_SPEED = 32'd6553600;
  localparam logic [30:0] RST_SPEED_LIMIT  = 31'd19660800;
  localparam logic [30:0] RST_ACCEL_RATE   = 31'd65536000;
  localparam logic [19:0] RST_INTERVAL_US  = 20'd10000;
  localparam logic [30:0] RST_MIN_LENGTH   = 31'd655;

  localparam logic [63:0] US_PER_S = 64'd1000000;
  localparam logic [63:0] HALF_US2 = 64'd2000000000000;

  typedef struct packed {
    logic [31:0] cruise_speed;
    logic [30:0] speed_limit;
    logic [30:0] accel_rate;
    logic [19:0] interval_us;
    logic [30:0] min_length;
  } tsi_cfg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic           start;
    alu_op_e        op;
    logic [127:0]   opa;
    logic [63:0]    opb;
  } tsi_alu_req_t;

endpackage

// ===== hdl/trapezoidal_segment_interpolator.sv =====
// Trapezoidal segment interpolator.
// Input channel (in_valid_i / in_stall_o) takes one segment: start and end
// point, Q16.16 mm. A transaction happens when valid is high and stall low.
// Output channel (out_valid_o / out_stall_i) returns the timed positions of
// the segment, the final one flagged by last_point_o. A short segment, or a
// clamped speed of zero, yields just the end point.
// Configuration writes (cfg_valid_i / cfg_ready_o, always ready) set the
// profile registers by index; write them only while the block is idle.
// All arithmetic runs on one shared unit: a shift-add multiplier (one bit of
// the multiplier per cycle, stops early), a restoring divider and a square
// root. The work for each emitted point is dominated by its divides: four,
// or two for the final point. One segment is processed at a time; in_stall_o
// stays high until the last point is handed to the output register. The
// output register holds a point while out_stall_i is high, and the sequencer
// waits for it to free before loading the next.
// Reset restores register defaults and empties the output register.
module trapezoidal_segment_interpolator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            start_x_i,
  input  logic signed [31:0]            start_y_i,
  input  logic signed [31:0]            end_x_i,
  input  logic signed [31:0]            end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic                          last_point_o,
  output logic                          count_capped_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam logic [64:0] NMAX = 65'(MAX_POINTS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_LEN, S_CHK, S_DA, S_BR, S_TRI_MUL, S_TRI_SQRT,
    S_TA_MUL, S_TA_DIV, S_TC_MUL, S_TC_DIV, S_TT_DIV, S_N, S_T_MUL, S_T_DIV,
    S_SEL, S_AT_MUL, S_AT2_MUL, S_S_DIV, S_C_MUL, S_C_DIV, S_AX_MUL,
    S_AX_DIV, S_AY_MUL, S_AY_DIV, S_EMIT
  } state_e;

  tsi_pkg::tsi_cfg_t     cfg;
  tsi_pkg::tsi_alu_req_t req;
  logic [127:0]          alu_res;
  logic                  alu_done;

  state_e state_q, state_d;
  logic   launched_q;
  logic   is_op;

  logic [31:0]  sx_q, sy_q, ex_q, ey_q;
  logic [32:0]  adx_q, ady_q;
  logic         negx_q, negy_q;
  logic [127:0] acc_q;
  logic [63:0]  len_q, da_q, vp_q, ta_q, tc_q, tt_q, t_q, u_q, at_q, s_q;
  logic         tri_q, decel_q, capped_q, last_q;
  logic [IW-1:0] n_q, i_q;
  logic [31:0]  px_q, py_q;

  logic         out_valid_q, last_point_q, count_capped_q;
  logic [31:0]  pos_x_q, pos_y_q;

  logic         in_acc, can_load, short_seg, tri_w;
  logic [30:0]  v_w, a_w;
  logic [19:0]  iv_w;
  logic [63:0]  tt_w, tac_w, q_w, sv_w, sxe, sye, posx_w, posy_w;
  logic [32:0]  dx_w, dy_w;
  logic [64:0]  nfull, nlim;
  logic [IW-1:0] i_inc;

  tsi_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (alu_res),
    .done_o (alu_done)
  );

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_acc         = in_valid_i && (state_q == S_IDLE);
  assign can_load       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign last_point_o   = last_point_q;
  assign count_capped_o = count_capped_q;

  always_comb begin
    if (cfg.cruise_speed[31]) v_w = '0;
    else if (cfg.cruise_speed[30:0] > cfg.speed_limit) v_w = cfg.speed_limit;
    else v_w = cfg.cruise_speed[30:0];
  end
  assign a_w  = (cfg.accel_rate == '0) ? 31'd1 : cfg.accel_rate;
  assign iv_w = (cfg.interval_us == '0) ? 20'd1 : cfg.interval_us;

  assign dx_w = {end_x_i[31], end_x_i} - {start_x_i[31], start_x_i};
  assign dy_w = {end_y_i[31], end_y_i} - {start_y_i[31], start_y_i};

  assign short_seg = (len_q < {33'd0, cfg.min_length}) || (v_w == '0);
  assign tri_w     = {da_q[62:0], 1'b0} >= len_q;
  assign tt_w      = {ta_q[62:0], 1'b0} + tc_q;
  assign tac_w     = ta_q + tc_q;
  assign q_w       = alu_res[63:0];
  assign i_inc     = i_q + 1'b1;

  assign nfull = {1'b0, acc_q[63:0]} + 65'd1;
  assign nlim  = (nfull < 65'd2) ? 65'd2 : nfull;

  always_comb begin
    if (state_q == S_S_DIV) begin
      if (decel_q) sv_w = (q_w >= len_q) ? 64'd0 : len_q - q_w;
      else sv_w = q_w;
    end else begin
      sv_w = da_q + q_w;
    end
  end

  assign sxe    = {{32{sx_q[31]}}, sx_q};
  assign sye    = {{32{sy_q[31]}}, sy_q};
  assign posx_w = negx_q ? sxe - q_w : sxe + q_w;
  assign posy_w = negy_q ? sye - q_w : sye + q_w;

  always_comb begin
    req.op  = tsi_pkg::ALU_MUL;
    req.opa = '0;
    req.opb = '0;
    is_op   = 1'b1;
    unique case (state_q)
      S_SQX: begin
        req.opa = {95'd0, adx_q};
        req.opb = {31'd0, adx_q};
      end
      S_SQY: begin
        req.opa = {95'd0, ady_q};
        req.opb = {31'd0, ady_q};
      end
      S_LEN: begin
        req.op  = tsi_pkg::ALU_SQRT;
        req.opa = acc_q;
      end
      S_CHK: begin
        req.opa = {97'd0, v_w};
        req.opb = {33'd0, v_w};
        is_op   = !short_seg;
      end
      S_DA: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = {32'd0, a_w, 1'b0};
      end
      S_TRI_MUL: begin
        req.opa = {97'd0, a_w};
        req.opb = len_q;
      end
      S_TRI_SQRT: begin
        req.op  = tsi_pkg::ALU_SQRT;
        req.opa = acc_q;
      end
      S_TA_MUL: begin
        req.opa = {64'd0, vp_q};
        req.opb = tsi_pkg::US_PER_S;
      end
      S_TA_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = {33'd0, a_w};
      end
      S_TC_MUL: begin
        req.opa = {64'd0, len_q - {da_q[62:0], 1'b0}};
        req.opb = tsi_pkg::US_PER_S;
      end
      S_TC_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = {33'd0, v_w};
      end
      S_TT_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = {64'd0, tt_w};
        req.opb = {44'd0, iv_w};
      end
      S_T_MUL: begin
        req.opa = {{(128-IW){1'b0}}, i_q};
        req.opb = tt_q;
      end
      S_T_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = {{(64-IW){1'b0}}, n_q};
      end
      S_AT_MUL: begin
        req.opa = {97'd0, a_w};
        req.opb = u_q;
      end
      S_AT2_MUL: begin
        req.opa = {64'd0, at_q};
        req.opb = u_q;
      end
      S_S_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = tsi_pkg::HALF_US2;
      end
      S_C_MUL: begin
        req.opa = {64'd0, vp_q};
        req.opb = t_q - ta_q;
      end
      S_C_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = tsi_pkg::US_PER_S;
      end
      S_AX_MUL: begin
        req.opa = {95'd0, adx_q};
        req.opb = s_q;
      end
      S_AX_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = len_q;
      end
      S_AY_MUL: begin
        req.opa = {95'd0, ady_q};
        req.opb = s_q;
      end
      S_AY_DIV: begin
        req.op  = tsi_pkg::ALU_DIV;
        req.opa = acc_q;
        req.opb = len_q;
      end
      default: is_op = 1'b0;
    endcase
    req.start = is_op && !launched_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = S_SQX;
      S_SQX:      if (alu_done) state_d = S_SQY;
      S_SQY:      if (alu_done) state_d = S_LEN;
      S_LEN:      if (alu_done) state_d = S_CHK;
      S_CHK: begin
        if (short_seg) state_d = S_EMIT;
        else if (alu_done) state_d = S_DA;
      end
      S_DA:       if (alu_done) state_d = S_BR;
      S_BR:       state_d = tri_w ? S_TRI_MUL : S_TA_MUL;
      S_TRI_MUL:  if (alu_done) state_d = S_TRI_SQRT;
      S_TRI_SQRT: if (alu_done) state_d = S_TA_MUL;
      S_TA_MUL:   if (alu_done) state_d = S_TA_DIV;
      S_TA_DIV:   if (alu_done) state_d = tri_q ? S_TT_DIV : S_TC_MUL;
      S_TC_MUL:   if (alu_done) state_d = S_TC_DIV;
      S_TC_DIV:   if (alu_done) state_d = S_TT_DIV;
      S_TT_DIV:   if (alu_done) state_d = S_N;
      S_N:        state_d = S_T_MUL;
      S_T_MUL:    if (alu_done) state_d = S_T_DIV;
      S_T_DIV:    if (alu_done) state_d = S_SEL;
      S_SEL: begin
        if (t_q <= ta_q) state_d = S_AT_MUL;
        else if (t_q <= tac_w) state_d = S_C_MUL;
        else state_d = S_AT_MUL;
      end
      S_AT_MUL:   if (alu_done) state_d = S_AT2_MUL;
      S_AT2_MUL:  if (alu_done) state_d = S_S_DIV;
      S_S_DIV:    if (alu_done) state_d = S_AX_MUL;
      S_C_MUL:    if (alu_done) state_d = S_C_DIV;
      S_C_DIV:    if (alu_done) state_d = S_AX_MUL;
      S_AX_MUL:   if (alu_done) state_d = S_AX_DIV;
      S_AX_DIV:   if (alu_done) state_d = S_AY_MUL;
      S_AY_MUL:   if (alu_done) state_d = S_AY_DIV;
      S_AY_DIV:   if (alu_done) state_d = S_EMIT;
      S_EMIT: begin
        if (can_load) begin
          if (last_q) state_d = S_IDLE;
          else if (i_inc == n_q) state_d = S_AX_MUL;
          else state_d = S_T_MUL;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      launched_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      last_point_q   <= 1'b0;
      count_capped_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req.start) launched_q <= 1'b1;
      else if (alu_done) launched_q <= 1'b0;
      if (state_q == S_EMIT && can_load) begin
        out_valid_q    <= 1'b1;
        pos_x_q        <= px_q;
        pos_y_q        <= py_q;
        last_point_q   <= last_q;
        count_capped_q <= capped_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sx_q   <= start_x_i;
          sy_q   <= start_y_i;
          ex_q   <= end_x_i;
          ey_q   <= end_y_i;
          negx_q <= dx_w[32];
          negy_q <= dy_w[32];
          adx_q  <= dx_w[32] ? -dx_w : dx_w;
          ady_q  <= dy_w[32] ? -dy_w : dy_w;
        end
      end
      S_SQX:      if (alu_done) acc_q <= alu_res;
      S_SQY:      if (alu_done) acc_q <= acc_q + alu_res;
      S_LEN:      if (alu_done) len_q <= alu_res[63:0];
      S_CHK: begin
        if (short_seg) begin
          px_q     <= ex_q;
          py_q     <= ey_q;
          last_q   <= 1'b1;
          capped_q <= 1'b0;
        end else if (alu_done) begin
          acc_q <= alu_res;
        end
      end
      S_DA:       if (alu_done) da_q <= q_w;
      S_BR: begin
        tri_q <= tri_w;
        if (!tri_w) vp_q <= {33'd0, v_w};
      end
      S_TRI_MUL:  if (alu_done) acc_q <= alu_res;
      S_TRI_SQRT: begin
        if (alu_done) begin
          vp_q <= q_w;
          da_q <= {1'b0, len_q[63:1]};
        end
      end
      S_TA_MUL:   if (alu_done) acc_q <= alu_res;
      S_TA_DIV: begin
        if (alu_done) begin
          ta_q <= q_w;
          if (tri_q) tc_q <= '0;
        end
      end
      S_TC_MUL:   if (alu_done) acc_q <= alu_res;
      S_TC_DIV:   if (alu_done) tc_q <= q_w;
      S_TT_DIV: begin
        if (alu_done) begin
          tt_q  <= tt_w;
          acc_q <= alu_res;
        end
      end
      S_N: begin
        i_q      <= '0;
        last_q   <= 1'b0;
        capped_q <= (nlim > NMAX);
        n_q      <= (nlim > NMAX) ? NMAX[IW-1:0] : nlim[IW-1:0];
      end
      S_T_MUL:    if (alu_done) acc_q <= alu_res;
      S_T_DIV:    if (alu_done) t_q <= q_w;
      S_SEL: begin
        if (t_q <= ta_q) begin
          u_q     <= t_q;
          decel_q <= 1'b0;
        end else if (t_q > tac_w) begin
          u_q     <= tt_q - t_q;
          decel_q <= 1'b1;
        end
      end
      S_AT_MUL:   if (alu_done) at_q <= q_w;
      S_AT2_MUL:  if (alu_done) acc_q <= alu_res;
      S_S_DIV, S_C_DIV: begin
        if (alu_done) s_q <= (sv_w > len_q) ? len_q : sv_w;
      end
      S_C_MUL:    if (alu_done) acc_q <= alu_res;
      S_AX_MUL:   if (alu_done) acc_q <= alu_res;
      S_AX_DIV:   if (alu_done) px_q <= (len_q == '0) ? sx_q : posx_w[31:0];
      S_AY_MUL:   if (alu_done) acc_q <= alu_res;
      S_AY_DIV:   if (alu_done) py_q <= (len_q == '0) ? sy_q : posy_w[31:0];
      S_EMIT: begin
        if (can_load && !last_q) begin
          i_q    <= i_inc;
          last_q <= (i_inc == n_q);
          if (i_inc == n_q) s_q <= len_q;
        end
      end
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("segment accepted but block not busy");

  a_point_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !last_q) |-> (i_q < n_q))
    else $error("point index beyond point count");

  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> launched_q)
    else $error("unit finished without a pending operation");

endmodule

// ===== hdl/tsi_regs.sv =====
module tsi_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output tsi_pkg::tsi_cfg_t             cfg_o
);

  tsi_pkg::tsi_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed <= tsi_pkg::RST_CRUISE_SPEED;
      cfg_q.speed_limit  <= tsi_pkg::RST_SPEED_LIMIT;
      cfg_q.accel_rate   <= tsi_pkg::RST_ACCEL_RATE;
      cfg_q.interval_us  <= tsi_pkg::RST_INTERVAL_US;
      cfg_q.min_length   <= tsi_pkg::RST_MIN_LENGTH;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tsi_pkg::REG_CRUISE_SPEED: cfg_q.cruise_speed <= cfg_data_i;
        tsi_pkg::REG_SPEED_LIMIT:  cfg_q.speed_limit  <= cfg_data_i[30:0];
        tsi_pkg::REG_ACCEL_RATE:   cfg_q.accel_rate   <= cfg_data_i[30:0];
        tsi_pkg::REG_INTERVAL_US:  cfg_q.interval_us  <= cfg_data_i[19:0];
        tsi_pkg::REG_MIN_LENGTH:   cfg_q.min_length   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/tsi_alu.sv =====
module tsi_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsi_pkg::tsi_alu_req_t req_i,
  output logic [127:0]          res_o,
  output logic                  done_o
);

  localparam logic [6:0] DIV_LAST  = 7'd127;
  localparam logic [6:0] SQRT_LAST = 7'd33;

  logic             busy_q;
  logic             done_q;
  tsi_pkg::alu_op_e op_q;
  logic [6:0]       cnt_q;

  logic [127:0] m_acc_q, m_cand_q;
  logic [63:0]  m_plier_q;
  logic [127:0] d_quo_q;
  logic [63:0]  d_rem_q, d_div_q;
  logic [67:0]  s_rad_q;
  logic [37:0]  s_rem_q;
  logic [33:0]  s_root_q;

  logic [64:0]  d_r2;
  logic         d_ge;
  logic [64:0]  d_diff;
  logic [37:0]  s_r2, s_trial;
  logic         s_ge;
  logic         finish;

  assign d_r2    = {d_rem_q, d_quo_q[127]};
  assign d_ge    = d_r2 >= {1'b0, d_div_q};
  assign d_diff  = d_r2 - {1'b0, d_div_q};
  assign s_r2    = {s_rem_q[35:0], s_rad_q[67:66]};
  assign s_trial = {2'b00, s_root_q, 2'b01};
  assign s_ge    = s_r2 >= s_trial;

  always_comb begin
    unique case (op_q)
      tsi_pkg::ALU_MUL:  finish = (m_plier_q == '0);
      tsi_pkg::ALU_DIV:  finish = (cnt_q == DIV_LAST);
      tsi_pkg::ALU_SQRT: finish = (cnt_q == SQRT_LAST);
      default:           finish = 1'b1;
    endcase
  end

  always_comb begin
    unique case (op_q)
      tsi_pkg::ALU_MUL:  res_o = m_acc_q;
      tsi_pkg::ALU_DIV:  res_o = (|d_quo_q[127:64]) ? {64'd0, {64{1'b1}}}
                                                    : {64'd0, d_quo_q[63:0]};
      tsi_pkg::ALU_SQRT: res_o = {94'd0, s_root_q};
      default:           res_o = '0;
    endcase
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= tsi_pkg::ALU_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (finish) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      m_acc_q   <= '0;
      m_cand_q  <= {64'd0, req_i.opa[63:0]};
      m_plier_q <= req_i.opb;
      d_quo_q   <= req_i.opa;
      d_rem_q   <= '0;
      d_div_q   <= req_i.opb;
      s_rad_q   <= req_i.opa[67:0];
      s_rem_q   <= '0;
      s_root_q  <= '0;
    end else if (busy_q) begin
      unique case (op_q)
        tsi_pkg::ALU_MUL: begin
          if (m_plier_q != '0) begin
            if (m_plier_q[0]) m_acc_q <= m_acc_q + m_cand_q;
            m_cand_q  <= {m_cand_q[126:0], 1'b0};
            m_plier_q <= {1'b0, m_plier_q[63:1]};
          end
        end
        tsi_pkg::ALU_DIV: begin
          d_rem_q <= d_ge ? d_diff[63:0] : d_r2[63:0];
          d_quo_q <= {d_quo_q[126:0], d_ge};
        end
        tsi_pkg::ALU_SQRT: begin
          s_rem_q  <= s_ge ? (s_r2 - s_trial) : s_r2;
          s_root_q <= {s_root_q[32:0], s_ge};
          s_rad_q  <= {s_rad_q[65:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/tb_trapezoidal_segment_interpolator.sv =====
module tb_trapezoidal_segment_interpolator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_POINTS = 64;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        last_point;
    logic        count_capped;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [tsi_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] start_x_i = '0;
  logic signed [31:0] start_y_i = '0;
  logic signed [31:0] end_x_i = '0;
  logic signed [31:0] end_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic        last_point_o;
  logic        count_capped_o;

  tsi_pkg::tsi_cfg_t prof;
  point_t      pending_points[$];
  int unsigned err_count = 0;
  int unsigned seg_count = 0;
  int unsigned point_count = 0;
  bit          out_burst = 1'b0;

  trapezoidal_segment_interpolator #(.MAX_POINTS(MAX_POINTS)) u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .last_point_o,
    .count_capped_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #(64'd2_000_000_000);
    $display("timeout: %0d points still pending", pending_points.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit [63:0] qdiv(bit [127:0] num, bit [63:0] den);
    bit [127:0] q;
    q = num / {64'd0, den};
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic bit [63:0] root128(bit [127:0] val);
    bit [63:0]  res;
    bit [63:0]  c;
    bit [127:0] sq;
    res = 0;
    for (int b = 34; b >= 0; b--) begin
      c = res | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= val) res = c;
    end
    return res;
  endfunction

  function automatic bit [31:0] place(longint s0, longint d, bit [63:0] ad,
                                      bit [63:0] s, bit [63:0] len);
    bit [63:0] mag;
    longint    r;
    if (len == 0) return s0[31:0];
    mag = qdiv({64'd0, ad} * {64'd0, s}, len);
    r = (d < 0) ? s0 - longint'(mag) : s0 + longint'(mag);
    return r[31:0];
  endfunction

  function automatic void trace_segment(logic signed [31:0] sx32, logic signed [31:0] sy32,
                                        logic signed [31:0] ex32, logic signed [31:0] ey32,
                                        ref point_t pts[$]);
    longint     sx, sy, ex, ey, dx, dy, cs;
    bit [63:0]  adx, ady, len, v, a, iv, d_acc, vp, t_acc, t_cru, t_tot, n, t, s, at, r, q;
    bit [127:0] sq;
    bit         capped;
    point_t     p;
    pts.delete();
    sx = sx32; sy = sy32; ex = ex32; ey = ey32;
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    sq = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
    len = root128(sq);
    cs = longint'(signed'(prof.cruise_speed));
    v = (cs < 0) ? 64'd0 : cs;
    if (v > prof.speed_limit) v = prof.speed_limit;
    a = (prof.accel_rate != 0) ? prof.accel_rate : 64'd1;
    iv = (prof.interval_us != 0) ? prof.interval_us : 64'd1;
    if (len < prof.min_length || v == 0) begin
      p.pos_x = ex32; p.pos_y = ey32; p.last_point = 1'b1; p.count_capped = 1'b0;
      pts.push_back(p);
      return;
    end
    d_acc = (v * v) / (2 * a);
    if (2 * d_acc >= len) begin
      vp = root128({64'd0, a} * {64'd0, len});
      t_acc = vp * tsi_pkg::US_PER_S / a;
      t_cru = 0;
      d_acc = len / 2;
    end else begin
      vp = v;
      t_acc = v * tsi_pkg::US_PER_S / a;
      t_cru = (len - 2 * d_acc) * tsi_pkg::US_PER_S / v;
    end
    t_tot = 2 * t_acc + t_cru;
    n = t_tot / iv + 1;
    if (n < 2) n = 2;
    capped = 1'b0;
    if (n > MAX_POINTS - 1) begin
      n = MAX_POINTS - 1;
      capped = 1'b1;
    end
    for (bit [63:0] i = 0; i <= n; i++) begin
      t = i * t_tot / n;
      if (t <= t_acc) begin
        at = a * t;
        s = qdiv({64'd0, at} * {64'd0, t}, tsi_pkg::HALF_US2);
      end else if (t <= t_acc + t_cru) begin
        s = d_acc + qdiv({64'd0, vp} * {64'd0, t - t_acc}, tsi_pkg::US_PER_S);
      end else begin
        r = t_tot - t;
        at = a * r;
        q = qdiv({64'd0, at} * {64'd0, r}, tsi_pkg::HALF_US2);
        s = (q >= len) ? 64'd0 : len - q;
      end
      if (s > len) s = len;
      if (i == n) s = len;
      p.pos_x = place(sx, dx, adx, s, len);
      p.pos_y = place(sy, dy, ady, s, len);
      p.last_point = (i == n);
      p.count_capped = capped;
      pts.push_back(p);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("mismatch %s: got %h want %h (point %0d)", what, got, want, point_count);
  endtask

  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      point_count++;
      if (pending_points.size() == 0) begin
        report("unexpected point", pos_x_o, 0);
      end else begin
        e = pending_points.pop_front();
        if (pos_x_o !== e.pos_x) report("pos_x", pos_x_o, e.pos_x);
        if (pos_y_o !== e.pos_y) report("pos_y", pos_y_o, e.pos_y);
        if (last_point_o !== e.last_point) report("last_point", last_point_o, e.last_point);
        if (count_capped_o !== e.count_capped)
          report("count_capped", count_capped_o, e.count_capped);
      end
    end
  end

  initial begin
    int k;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
      k = out_burst ? 0 : $urandom_range(0, 10);
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(logic [tsi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tsi_pkg::REG_CRUISE_SPEED: prof.cruise_speed = data;
      tsi_pkg::REG_SPEED_LIMIT:  prof.speed_limit  = data[30:0];
      tsi_pkg::REG_ACCEL_RATE:   prof.accel_rate   = data[30:0];
      tsi_pkg::REG_INTERVAL_US:  prof.interval_us  = data[19:0];
      tsi_pkg::REG_MIN_LENGTH:   prof.min_length   = data[30:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                              logic [31:0] ey);
    point_t pts[$];
    int     gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i   <= ex;
    end_y_i   <= ey;
    do @(posedge clk_i); while (in_stall_o);
    trace_segment(sx, sy, ex, ey, pts);
    foreach (pts[j]) pending_points.push_back(pts[j]);
    seg_count++;
  endtask

  task automatic test_default_profile();
    send_segment(0, 0, 0, 0);
    send_segment(32'h0001_0000, 0, 32'h0001_0064, 0);
    send_segment(0, 0, 655, 0);
    send_segment(0, 0, 32'h000A_0000, 0);
    send_segment(32'h0005_0000, 32'h0005_0000, 32'hFFFB_0000, 32'hFFD0_0000);
    send_segment(0, 0, 32'h0000_0100, 32'h0032_0000);
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_segment(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h0000_0010);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(tsi_pkg::REG_CRUISE_SPEED, 32'h8000_0000);
    cfg_done();
    send_segment(0, 0, 32'h0004_0000, 32'h0003_0000);
    drain();
    write_reg(tsi_pkg::REG_CRUISE_SPEED, 32'h7FFF_FFFF);
    write_reg(tsi_pkg::REG_SPEED_LIMIT, 32'h7FFF_FFFF);
    write_reg(tsi_pkg::REG_ACCEL_RATE, 32'h7FFF_FFFF);
    write_reg(tsi_pkg::REG_INTERVAL_US, 32'hFFFF_FFFF);
    write_reg(tsi_pkg::REG_MIN_LENGTH, 32'd0);
    cfg_done();
    send_segment(0, 0, 0, 0);
    send_segment(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h1234_5678);
    drain();
    write_reg(tsi_pkg::REG_SPEED_LIMIT, 32'd0);
    cfg_done();
    send_segment(0, 0, 32'h0010_0000, 0);
    drain();
    write_reg(tsi_pkg::REG_SPEED_LIMIT, 32'h0064_0000);
    write_reg(tsi_pkg::REG_ACCEL_RATE, 32'd0);
    write_reg(tsi_pkg::REG_INTERVAL_US, 32'd0);
    cfg_done();
    send_segment(0, 0, 32'h0000_0800, 32'h0000_0400);
    drain();
    write_reg(tsi_pkg::REG_ACCEL_RATE, 32'h03E8_0000);
    write_reg(tsi_pkg::REG_INTERVAL_US, 32'd1_000_000);
    write_reg(tsi_pkg::REG_MIN_LENGTH, 32'h7FFF_FFFF);
    cfg_done();
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    write_reg(tsi_pkg::REG_MIN_LENGTH, 32'd655);
    cfg_done();
    send_segment(0, 0, 32'h0000_0100, 0);
    send_segment(0, 0, 32'h0064_0000, 32'hFF9C_0000);
    drain();
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1, 2: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
      default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
  endfunction

  task automatic random_profile();
    case ($urandom_range(0, 5))
      0: write_reg(tsi_pkg::REG_CRUISE_SPEED, $urandom());
      1: write_reg(tsi_pkg::REG_CRUISE_SPEED, 32'h8000_0000 | $urandom());
      default: write_reg(tsi_pkg::REG_CRUISE_SPEED, $urandom_range(1, 32'h0400_0000));
    endcase
    write_reg(tsi_pkg::REG_SPEED_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom()
                                         : $urandom_range(0, 32'h0400_0000));
    write_reg(tsi_pkg::REG_ACCEL_RATE, ($urandom_range(0, 3) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h4000_0000));
    write_reg(tsi_pkg::REG_INTERVAL_US, ($urandom_range(0, 3) == 0) ? $urandom()
                                         : $urandom_range(1000, 200000));
    write_reg(tsi_pkg::REG_MIN_LENGTH, ($urandom_range(0, 5) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h0001_0000));
    cfg_done();
  endtask

  task automatic test_random_segments();
    point_t      pts[$];
    logic [31:0] c[4];
    for (int g = 0; g < 10; g++) begin
      random_profile();
      for (int k = 0; k < 20; k++) begin
        for (int tries = 0; tries < 8; tries++) begin
          foreach (c[j]) c[j] = rand_coord();
          if ($urandom_range(0, 7) == 0) c[2] = c[0] + $urandom_range(0, 3);
          trace_segment(c[0], c[1], c[2], c[3], pts);
          if (pts.size() <= 12 || $urandom_range(0, 9) == 0) break;
        end
        send_segment(c[0], c[1], c[2], c[3]);
      end
      drain();
    end
  endtask

  task automatic test_paused_sender();
    write_reg(tsi_pkg::REG_CRUISE_SPEED, tsi_pkg::RST_CRUISE_SPEED);
    write_reg(tsi_pkg::REG_SPEED_LIMIT, {1'b0, tsi_pkg::RST_SPEED_LIMIT});
    write_reg(tsi_pkg::REG_ACCEL_RATE, {1'b0, tsi_pkg::RST_ACCEL_RATE});
    write_reg(tsi_pkg::REG_INTERVAL_US, 32'd50000);
    write_reg(tsi_pkg::REG_MIN_LENGTH, {1'b0, tsi_pkg::RST_MIN_LENGTH});
    cfg_done();
    for (int k = 0; k < 6; k++) begin
      send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  initial begin
    prof = '{tsi_pkg::RST_CRUISE_SPEED, tsi_pkg::RST_SPEED_LIMIT, tsi_pkg::RST_ACCEL_RATE,
             tsi_pkg::RST_INTERVAL_US, tsi_pkg::RST_MIN_LENGTH};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_profile();
    test_register_extremes();
    test_random_segments();
    test_paused_sender();
    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d segments and %0d emitted points across default, extreme",
             seg_count, point_count);
    $display("and randomized motion profiles; %0d mismatches", err_count);
    if (err_count == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
